### rtl/mcit_pkg.sv
// Shared types and constants for the multi-channel interval timer.
package mcit_pkg;

    localparam int NUM_SLOTS_DEF   = 16;
    localparam int PERIOD_BITS_DEF = 24;
    localparam int ID_W            = 4;
    localparam int IVAL_W          = 24;
    localparam int CNT_W           = 32;
    localparam int QUEUE_DEPTH     = 2;

    // command codes as they arrive on the input channel
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_RESET = 3'd2,
        CMD_QUERY = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_code_t;

    // decoded operation handed from the front to the back
    typedef enum logic [2:0] {
        OP_START,
        OP_STOP,
        OP_RESET,
        OP_QUERY,
        OP_TICK,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              in_range;
        logic [ID_W-1:0]   id;
        logic [IVAL_W-1:0] interval;
        logic              rep;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FLUSH
    } back_state_t;

    typedef struct packed {
        logic              kind;
        logic              ok;
        logic [ID_W-1:0]   slot;
        logic              active;
        logic              periodic;
        logic [IVAL_W-1:0] period;
        logic [CNT_W-1:0]  count;
        logic              last;
    } result_t;

endpackage

### rtl/mcit_front.sv
// Input stage: decodes each command and checks the slot id against the table size.
module mcit_front #(
    parameter int NUM_SLOTS = mcit_pkg::NUM_SLOTS_DEF
) (
    input  logic [2:0]              cmd,
    input  logic [mcit_pkg::ID_W-1:0]   timer_id,
    input  logic [mcit_pkg::IVAL_W-1:0] interval_ms,
    input  logic                    repeat_req,
    output mcit_pkg::item_t         item
);
    import mcit_pkg::*;

    op_t  op;
    logic in_range;

    always_comb begin
        unique case (cmd)
            CMD_START: op = OP_START;
            CMD_STOP:  op = OP_STOP;
            CMD_RESET: op = OP_RESET;
            CMD_QUERY: op = OP_QUERY;
            CMD_TICK:  op = OP_TICK;
            default:   op = OP_BAD;
        endcase
    end

    assign in_range = 32'(timer_id) < 32'(NUM_SLOTS);

    assign item = '{op: op, in_range: in_range, id: timer_id, interval: interval_ms,
                    rep: repeat_req};

endmodule

### rtl/mcit_queue.sv
// Short queue of decoded commands between the front and the back.
module mcit_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mcit_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output mcit_pkg::item_t head
);
    import mcit_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = count_reg == CW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/mcit_back.sv
// Execution sequencer: slot table, command execution, tick scan and result register.
module mcit_back #(
    parameter int NUM_SLOTS   = mcit_pkg::NUM_SLOTS_DEF,
    parameter int PERIOD_BITS = mcit_pkg::PERIOD_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  mcit_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              out_valid,
    output mcit_pkg::result_t out_data,
    input  logic              out_ready
);
    import mcit_pkg::*;

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [63:0] PMASK = (64'd1 << PERIOD_BITS) - 64'd1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SLOTS - 1);

    // slot table; contents of a free slot are never shown
    logic                   mem_per [NUM_SLOTS];
    logic [PERIOD_BITS-1:0] mem_rel [NUM_SLOTS];
    logic [PERIOD_BITS-1:0] mem_rem [NUM_SLOTS];
    logic [CNT_W-1:0]       mem_cnt [NUM_SLOTS];

    logic                   rd_per_reg;
    logic [PERIOD_BITS-1:0] rd_rel_reg;
    logic [PERIOD_BITS-1:0] rd_rem_reg;
    logic [CNT_W-1:0]       rd_cnt_reg;

    logic [NUM_SLOTS-1:0]   busy_reg, busy_next;
    back_state_t            state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [AW-1:0]          cur_reg, cur_next;
    logic                   pend_valid_reg, pend_valid_next;
    result_t                pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   wr_per;
    logic [PERIOD_BITS-1:0] wr_rel;
    logic [PERIOD_BITS-1:0] wr_rem;
    logic [CNT_W-1:0]       wr_cnt;

    logic                   out_free;
    logic [AW-1:0]          item_addr;
    logic                   busy_item;
    logic [63:0]            iv64;
    logic [63:0]            clamped;
    logic [PERIOD_BITS-1:0] ival;
    logic [PERIOD_BITS-1:0] rem_dec;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   advance;
    logic                   a_busy;
    logic                   a_per;
    logic [PERIOD_BITS-1:0] a_rel;
    logic [CNT_W-1:0]       a_cnt;
    result_t                res;
    result_t                fire;

    assign out_free  = !out_valid_reg || out_ready;
    assign item_addr = AW'(item_reg.id);
    assign busy_item = item_reg.in_range && busy_reg[item_addr];
    assign rem_dec   = rd_rem_reg - PERIOD_BITS'(1);
    assign cnt_inc   = (rd_cnt_reg == '1) ? rd_cnt_reg : rd_cnt_reg + CNT_W'(1);

    // zero acts as one, anything above the period range saturates
    always_comb begin
        iv64    = 64'(item_reg.interval);
        clamped = (iv64 > PMASK) ? PMASK : iv64;
        if (clamped == 64'd0) begin
            clamped = 64'd1;
        end
        ival = PERIOD_BITS'(clamped);
    end

    always_comb begin
        fire = '{kind: 1'b1, ok: 1'b1, slot: ID_W'(cur_reg), active: rd_per_reg,
                 periodic: rd_per_reg, period: IVAL_W'(rd_rel_reg), count: cnt_inc,
                 last: 1'b0};
    end

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        cur_next        = cur_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        busy_next       = busy_reg;
        q_pop           = 1'b0;
        rd_addr         = cur_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_per          = rd_per_reg;
        wr_rel          = rd_rel_reg;
        wr_rem          = rd_rem_reg;
        wr_cnt          = rd_cnt_reg;
        advance         = 1'b1;
        a_busy          = busy_item;
        a_per           = rd_per_reg;
        a_rel           = rd_rel_reg;
        a_cnt           = rd_cnt_reg;
        res             = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.op == OP_TICK) begin
                        state_next = ST_SCAN;
                        cur_next   = '0;
                        rd_addr    = '0;
                    end else begin
                        state_next = ST_EXEC;
                        rd_addr    = AW'(q_item.id);
                    end
                end
            end

            ST_EXEC: begin
                rd_addr = item_addr;
                wr_addr = item_addr;
                res.ok  = 1'b0;
                case (item_reg.op)
                    OP_START: begin
                        if (item_reg.in_range && !busy_item) begin
                            res.ok               = 1'b1;
                            wr_en                = 1'b1;
                            wr_per               = item_reg.rep;
                            wr_rel               = ival;
                            wr_rem               = ival;
                            wr_cnt               = '0;
                            busy_next[item_addr] = 1'b1;
                            a_busy               = 1'b1;
                            a_per                = item_reg.rep;
                            a_rel                = ival;
                            a_cnt                = '0;
                        end
                    end
                    OP_STOP: begin
                        if (busy_item) begin
                            res.ok               = 1'b1;
                            busy_next[item_addr] = 1'b0;
                            a_busy               = 1'b0;
                        end
                    end
                    OP_RESET: begin
                        if (busy_item) begin
                            res.ok = 1'b1;
                            wr_en  = 1'b1;
                            wr_per = item_reg.rep;
                            wr_rel = ival;
                            wr_rem = ival;
                            a_per  = item_reg.rep;
                            a_rel  = ival;
                        end
                    end
                    OP_QUERY: begin
                        res.ok = busy_item;
                    end
                    default: begin
                        a_busy = 1'b0;
                    end
                endcase
                res.kind = 1'b0;
                res.slot = item_reg.id;
                res.last = 1'b1;
                if (a_busy) begin
                    res.active   = 1'b1;
                    res.periodic = a_per;
                    res.period   = IVAL_W'(a_rel);
                    res.count    = a_cnt;
                end
                if (out_free) begin
                    out_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    wr_en     = 1'b0;
                    busy_next = busy_reg;
                end
            end

            ST_SCAN: begin
                if (busy_reg[cur_reg]) begin
                    if (rem_dec != '0) begin
                        wr_en  = 1'b1;
                        wr_rem = rem_dec;
                    end else if (pend_valid_reg && !out_free) begin
                        // hold this slot until the held fire can go out
                        advance = 1'b0;
                    end else begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = fire;
                        pend_valid_next = 1'b1;
                        wr_en           = 1'b1;
                        wr_rem          = rd_rel_reg;
                        wr_cnt          = cnt_inc;
                        if (!rd_per_reg) begin
                            busy_next[cur_reg] = 1'b0;
                        end
                    end
                end
                if (advance) begin
                    rd_addr = cur_reg + AW'(1);
                    if (cur_reg == LAST_SLOT) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cur_next = cur_reg + AW'(1);
                    end
                end
            end

            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            busy_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cur_reg        <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_per[wr_addr] <= wr_per;
            mem_rel[wr_addr] <= wr_rel;
            mem_rem[wr_addr] <= wr_rem;
            mem_cnt[wr_addr] <= wr_cnt;
        end
        rd_per_reg <= mem_per[rd_addr];
        rd_rel_reg <= mem_rel[rd_addr];
        rd_rem_reg <= mem_rem[rd_addr];
        rd_cnt_reg <= mem_cnt[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/multi_channel_interval_timer.sv
// A command is popped by the idle state, which reads its slot, and the exec state loads the reply
// once the result port is free; a tick scans the table at one slot per cycle, pausing while a held
// fire waits on a stalled result port. Commands run one at a time; the registered table read sets the pace.
// Fires leave lowest slot first; the last result of each transaction carries tlast.
// Reset: synchronous, active low; all slots free, queue and result register empty.
module multi_channel_interval_timer #(
    parameter int NUM_SLOTS   = mcit_pkg::NUM_SLOTS_DEF,
    parameter int PERIOD_BITS = mcit_pkg::PERIOD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // cmd[2:0], timer_id[6:3], interval_ms[30:7], repeat_req[31]
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], slot_id[4:1], active[5], periodic[6], period[30:7], fire_count[62:31], zero[63]
    output logic [63:0] m_tdata,
    output logic        m_tuser,  // kind
    output logic        m_tlast
);
    import mcit_pkg::*;

    item_t   dec_item;
    item_t   q_head;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    logic    push;
    result_t res;

    assign push     = s_tvalid && !q_full;
    assign s_tready = !q_full;

    mcit_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .cmd        (s_tdata[2:0]),
        .timer_id   (s_tdata[6:3]),
        .interval_ms(s_tdata[30:7]),
        .repeat_req (s_tdata[31]),
        .item       (dec_item)
    );

    mcit_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(dec_item),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head     (q_head)
    );

    mcit_back #(
        .NUM_SLOTS  (NUM_SLOTS),
        .PERIOD_BITS(PERIOD_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_data (res),
        .out_ready(m_tready)
    );

    assign m_tdata = {1'b0, res.count, res.period, res.periodic, res.active, res.slot, res.ok};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

### sim/tb_top.sv
// Testbench for the multi-channel interval timer: directed and random command streams.
`timescale 1ns / 1ps

module tb_top;
    import mcit_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [23:0] IVAL_MAX = 24'hFFFFFF;

    typedef struct {
        logic        kind;
        logic        ok;
        logic [3:0]  slot;
        logic        active;
        logic        periodic;
        logic [23:0] period;
        logic [31:0] count;
        logic        last;
    } timer_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // model of the slot table
    logic        slot_busy [SLOTS];
    logic        slot_rep  [SLOTS];
    logic [23:0] slot_reload [SLOTS];
    logic [23:0] slot_left [SLOTS];
    logic [31:0] slot_fired [SLOTS];

    timer_result_t pending_results[$];
    int errors;
    int burst_left;
    logic stall_mode;

    multi_channel_interval_timer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),  // cmd, timer_id, interval_ms, repeat_req
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),  // ok, slot_id, active, periodic, period, fire_count, zero
        .m_tuser  (m_tuser),  // kind
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("tb_top: errors");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic timer_result_t slot_view(input logic kind, input logic ok,
                                                input logic [3:0] s, input logic payload);
        timer_result_t r;
        r = '{default: '0};
        r.kind = kind;
        r.ok   = ok;
        r.slot = s;
        if (payload && slot_busy[s]) begin
            r.active   = 1'b1;
            r.periodic = slot_rep[s];
            r.period   = slot_reload[s];
            r.count    = slot_fired[s];
        end
        return r;
    endfunction

    // work out what one command produces and advance the slot table
    task automatic predict_command(input logic [2:0] cmd, input logic [3:0] id,
                                   input logic [23:0] ival_in, input logic rep);
        logic [23:0] ival;
        logic ok;
        int n;
        timer_result_t r;
        ival = (ival_in == 0) ? 24'd1 : ival_in;
        ok = 1'b0;
        n = 0;
        if (cmd == CMD_TICK) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (!slot_busy[s]) continue;
                slot_left[s] = slot_left[s] - 1'b1;
                if (slot_left[s] != 0) continue;
                if (slot_fired[s] != 32'hFFFFFFFF) slot_fired[s]++;
                r = slot_view(1'b1, 1'b1, s[3:0], 1'b1);
                if (slot_rep[s]) begin
                    slot_left[s] = slot_reload[s];
                end else begin
                    slot_busy[s] = 1'b0;
                    r.active = 1'b0;
                end
                pending_results = {pending_results, r};
                n++;
            end
            if (n > 0) pending_results[$].last = 1'b1;
            return;
        end
        case (cmd)
            CMD_START: if (!slot_busy[id]) begin
                slot_busy[id] = 1'b1;
                slot_rep[id] = rep;
                slot_reload[id] = ival;
                slot_left[id] = ival;
                slot_fired[id] = 0;
                ok = 1'b1;
            end
            CMD_STOP: if (slot_busy[id]) begin
                slot_busy[id] = 1'b0;
                ok = 1'b1;
            end
            CMD_RESET: if (slot_busy[id]) begin
                slot_rep[id] = rep;
                slot_reload[id] = ival;
                slot_left[id] = ival;
                ok = 1'b1;
            end
            CMD_QUERY: ok = slot_busy[id];
            default: ;
        endcase
        r = slot_view(1'b0, ok, id, cmd <= CMD_QUERY);
        r.last = 1'b1;
        pending_results = {pending_results, r};
    endtask

    // send one command; gaps come between random-length bursts
    task automatic send_command(input logic [2:0] cmd, input logic [3:0] id,
                                input logic [23:0] ival, input logic rep);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tdata  <= {rep, ival, id, cmd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_command(cmd, id, ival, rep);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            send_command(CMD_TICK, 4'($urandom), 24'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (40) @(negedge aclk);
    endtask

    // receiver stalls: alternate between a random pattern and always ready
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
            m_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        timer_result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", m_tdata, 0);
            end else begin
                w = pending_results.pop_front();
                if (m_tuser !== w.kind) report("kind", m_tuser, w.kind);
                if (m_tdata[0] !== w.ok) report("ok", m_tdata[0], w.ok);
                if (m_tdata[4:1] !== w.slot) report("slot_id", m_tdata[4:1], w.slot);
                if (m_tdata[5] !== w.active) report("active", m_tdata[5], w.active);
                if (m_tdata[6] !== w.periodic) report("periodic", m_tdata[6], w.periodic);
                if (m_tdata[30:7] !== w.period) report("period", m_tdata[30:7], w.period);
                if (m_tdata[62:31] !== w.count) report("fire_count", m_tdata[62:31], w.count);
                if (m_tdata[63] !== 1'b0) report("pad", m_tdata[63], 0);
                if (m_tlast !== w.last) report("last", m_tlast, w.last);
            end
        end
    end

    task automatic test_directed();
        send_command(CMD_QUERY, 4'd0, 24'd0, 1'b0);
        send_command(CMD_STOP, 4'd3, 24'd0, 1'b0);
        send_command(CMD_RESET, 4'd3, 24'd5, 1'b1);
        send_command(CMD_START, 4'd0, 24'd0, 1'b0);   // zero interval acts as 1
        send_command(CMD_START, 4'd15, 24'd2, 1'b1);
        send_command(CMD_START, 4'd7, IVAL_MAX, 1'b1);
        send_command(CMD_START, 4'd0, 24'd9, 1'b1);   // already busy
        send_command(CMD_QUERY, 4'd15, 24'd0, 1'b0);
        send_ticks(1);
        send_command(CMD_START, 4'd1, 24'd1, 1'b1);
        send_command(CMD_START, 4'd2, 24'd1, 1'b0);
        send_ticks(3);
        send_command(CMD_RESET, 4'd15, 24'd0, 1'b0);
        send_command(CMD_QUERY, 4'd15, 24'd0, 1'b1);
        send_command(3'd5, 4'd1, IVAL_MAX, 1'b1);
        send_command(3'd6, 4'd2, 24'd1, 1'b0);
        send_command(3'd7, 4'd15, 24'd3, 1'b1);
        send_ticks(2);
        send_command(CMD_STOP, 4'd1, 24'd0, 1'b0);
        send_command(CMD_STOP, 4'd7, IVAL_MAX, 1'b1);
        send_command(CMD_QUERY, 4'd7, 24'd0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random();
        logic [2:0] cmd;
        logic [23:0] ival;
        for (int i = 0; i < 300; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    cmd = CMD_START;
                2:       cmd = CMD_STOP;
                3:       cmd = CMD_RESET;
                4:       cmd = CMD_QUERY;
                5:       cmd = 3'($urandom_range(5, 7));
                default: cmd = CMD_TICK;
            endcase
            // mostly short intervals so slots fire; some full-width values
            ival = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
            send_command(cmd, 4'($urandom), ival, 1'($urandom));
            if (i == 150) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        errors = 0;
        burst_left = 0;
        stall_mode = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_busy[s] = 0;
            slot_rep[s] = 0;
            slot_reload[s] = 0;
            slot_left[s] = 0;
            slot_fired[s] = 0;
        end
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
